// ----- sv/kvt_pkg.sv -----
`default_nettype none

package kvt_pkg;

    // Fixed widths of the item fields on the ports.
    localparam int FIELD_BITS  = 32;
    localparam int OP_BITS     = 2;
    localparam int COUNT_OUT_W = 5;

    // Request queue between front and back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef enum logic [OP_BITS-1:0] {
        OP_ADD      = 2'd0,
        OP_FIND     = 2'd1,
        OP_RETRIEVE = 2'd2,
        OP_REMOVE   = 2'd3
    } op_t;

    typedef struct packed {
        op_t                   op;
        logic [FIELD_BITS-1:0] key;
        logic [FIELD_BITS-1:0] value;
    } req_t;

endpackage : kvt_pkg

`default_nettype wire

// ----- sv/kvt_front.sv -----
`default_nettype none

module kvt_front #(
    parameter int KEY_W   = 32,
    parameter int VALUE_W = 32
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic [kvt_pkg::OP_BITS-1:0]      s_operation,
    input  wire logic [kvt_pkg::FIELD_BITS-1:0]   s_key,
    input  wire logic [kvt_pkg::FIELD_BITS-1:0]   s_value,
    output logic                                  q_valid,
    input  wire logic                             q_pop,
    output kvt_pkg::req_t                         q_head
);
    import kvt_pkg::*;

    localparam logic [FIELD_BITS-1:0] KEY_MASK   = FIELD_BITS'((64'd1 << KEY_W) - 64'd1);
    localparam logic [FIELD_BITS-1:0] VALUE_MASK = FIELD_BITS'((64'd1 << VALUE_W) - 64'd1);

    req_t              q_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   cnt_reg, cnt_next;
    logic              push;
    req_t              req_in;

    // decode: op code to enum, unused key/value bits cleared
    always_comb begin
        req_in.key   = s_key & KEY_MASK;
        req_in.value = (s_operation == OP_ADD) ? (s_value & VALUE_MASK) : '0;
        unique case (s_operation)
            OP_ADD:      req_in.op = OP_ADD;
            OP_FIND:     req_in.op = OP_FIND;
            OP_RETRIEVE: req_in.op = OP_RETRIEVE;
            default:     req_in.op = OP_REMOVE;
        endcase
    end

    assign s_ready = (cnt_reg != (QPTR_W+1)'(QUEUE_DEPTH));
    assign push    = s_valid && s_ready;
    assign q_valid = (cnt_reg != '0);
    assign q_head  = q_mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push  ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = q_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !q_pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (!push && q_pop) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem[wr_ptr_reg] <= req_in;
        end
    end

    q_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> q_valid)
        else $error("pop from empty request queue");

    q_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= (QPTR_W+1)'(QUEUE_DEPTH))
        else $error("request queue count out of range");

    q_count_track: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !q_pop) |=> (cnt_reg == $past(cnt_reg) + 1'b1))
        else $error("request queue count did not follow push");

endmodule : kvt_front

`default_nettype wire

// ----- sv/kvt_back.sv -----
`default_nettype none

module kvt_back #(
    parameter int CAPACITY = 16,
    parameter int KEY_W    = 32,
    parameter int VALUE_W  = 32
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               q_valid,
    output logic                                    q_pop,
    input  wire kvt_pkg::req_t                      q_head,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic                                    m_ok,
    output logic                                    m_full_reject,
    output logic [kvt_pkg::FIELD_BITS-1:0]          m_value_out,
    output logic [kvt_pkg::COUNT_OUT_W-1:0]         m_entry_count,
    output logic                                    m_is_empty
);
    import kvt_pkg::*;

    localparam int COUNT_W = $clog2(CAPACITY + 1);

    typedef enum logic {
        ST_LOOKUP,
        ST_EXEC
    } state_t;

    // entry store, no reset: only read where valid
    logic [KEY_W-1:0]   entry_key   [CAPACITY];
    logic [VALUE_W-1:0] entry_value [CAPACITY];

    state_t               state_reg, state_next;
    req_t                 req_reg, req_next;
    logic [CAPACITY-1:0]  hit_reg, hit_next;
    logic [CAPACITY-1:0]  free_reg, free_next;
    logic [CAPACITY-1:0]  valid_reg, valid_next;
    logic [COUNT_W-1:0]   count_reg, count_next;

    logic                   out_valid_reg, out_valid_next;
    logic                   out_ok_reg, out_ok_next;
    logic                   out_full_reg, out_full_next;
    logic [FIELD_BITS-1:0]  out_value_reg, out_value_next;
    logic [COUNT_OUT_W-1:0] out_count_reg, out_count_next;
    logic                   out_empty_reg, out_empty_next;

    logic                   fire;
    logic                   found;
    logic                   do_write;
    logic [VALUE_W-1:0]     value_sel;
    logic [CAPACITY-1:0]    free_vec;
    logic [FIELD_BITS-1:0]  count_ext;

    // all-slot compare and free-slot vector (its lowest set bit is isolated on pop)
    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            hit_next[i] = valid_reg[i] && (entry_key[i] == q_head.key[KEY_W-1:0]);
        end
        free_vec = ~valid_reg;
    end

    always_comb begin
        value_sel = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            value_sel = value_sel | (entry_value[i] & {VALUE_W{hit_reg[i]}});
        end
    end

    assign found = |hit_reg;
    assign fire  = (state_reg == ST_EXEC) && (!out_valid_reg || m_ready);

    always_comb begin
        state_next     = state_reg;
        req_next       = req_reg;
        free_next      = free_reg;
        valid_next     = valid_reg;
        count_next     = count_reg;
        q_pop          = 1'b0;
        do_write       = 1'b0;
        out_valid_next = (out_valid_reg && !m_ready);
        out_ok_next    = out_ok_reg;
        out_full_next  = out_full_reg;
        out_value_next = out_value_reg;
        out_count_next = out_count_reg;
        out_empty_next = out_empty_reg;
        count_ext      = '0;

        unique case (state_reg)
            ST_LOOKUP: begin
                if (q_valid) begin
                    q_pop      = 1'b1;
                    req_next   = q_head;
                    free_next  = free_vec & (~free_vec + 1'b1);
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (fire) begin
                    out_ok_next    = 1'b0;
                    out_full_next  = 1'b0;
                    out_value_next = '0;
                    case (req_reg.op)
                        OP_ADD: begin
                            if (!found) begin
                                if (count_reg >= COUNT_W'(CAPACITY)) begin
                                    out_full_next = 1'b1;
                                end else begin
                                    do_write    = 1'b1;
                                    valid_next  = valid_reg | free_reg;
                                    count_next  = count_reg + 1'b1;
                                    out_ok_next = 1'b1;
                                end
                            end
                        end
                        OP_FIND: begin
                            out_ok_next = found;
                        end
                        OP_RETRIEVE: begin
                            out_ok_next = found;
                            if (found) begin
                                out_value_next = FIELD_BITS'(value_sel);
                            end
                        end
                        default: begin
                            if (found) begin
                                valid_next  = valid_reg & ~hit_reg;
                                count_next  = count_reg - 1'b1;
                                out_ok_next = 1'b1;
                            end
                        end
                    endcase
                    count_ext      = FIELD_BITS'(count_next);
                    out_count_next = count_ext[COUNT_OUT_W-1:0];
                    out_empty_next = (count_next == '0);
                    out_valid_next = 1'b1;
                    state_next     = ST_LOOKUP;
                end
            end
            default: state_next = ST_LOOKUP;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_LOOKUP;
            valid_reg     <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
        req_reg       <= req_next;
        hit_reg       <= (state_reg == ST_LOOKUP) ? hit_next : hit_reg;
        free_reg      <= free_next;
        out_ok_reg    <= out_ok_next;
        out_full_reg  <= out_full_next;
        out_value_reg <= out_value_next;
        out_count_reg <= out_count_next;
        out_empty_reg <= out_empty_next;
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < CAPACITY; i++) begin
            if (do_write && free_reg[i]) begin
                entry_key[i]   <= req_reg.key[KEY_W-1:0];
                entry_value[i] <= req_reg.value[VALUE_W-1:0];
            end
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_ok          = out_ok_reg;
    assign m_full_reject = out_full_reg;
    assign m_value_out   = out_value_reg;
    assign m_entry_count = out_count_reg;
    assign m_is_empty    = out_empty_reg;

    count_matches_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(valid_reg) == int'(count_reg))
        else $error("entry count differs from number of valid slots");

    count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= COUNT_W'(CAPACITY))
        else $error("entry count above capacity");

    unique_keys: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EXEC) |-> $onehot0(hit_reg))
        else $error("key present in more than one slot");

    ok_full_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> !(out_ok_reg && out_full_reg))
        else $error("result flagged both ok and full");

    value_needs_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !out_ok_reg) |-> (out_value_reg == '0))
        else $error("value returned without a hit");

endmodule : kvt_back

`default_nettype wire

// ----- sv/key_value_table.sv -----
// key_value_table: bounded associative store with unique keys.
// Input channel (s_*): one item per handshake; operation 0 add, 1 find,
//   2 retrieve, 3 remove, with key and value (value used by add only).
// Result channel (m_*): exactly one result item per input item, in order:
//   ok, full_reject, value_out, entry_count and is_empty after the op.
// Front: decodes the item and pushes it into a two-entry request queue.
// Back: compares the key against every slot at once (one comparator per
//   slot), registers the hit vector and lowest free slot, then executes
//   and loads the result register.
// Path: the queue entry, then the registered lookup, then the result register.
// The back takes a new item only after it has executed the last one, as its
//   lookup and execute steps share a single set of slot registers.
// Key/value bits above KEY_BITS/VALUE_BITS are dropped; keys and values are
//   stored at most 32 bits wide.
// Reset (aresetn low, synchronous): table emptied, count zero, queue
//   emptied and m_valid cleared. Ready to accept on the first cycle after.
// Receiver stall: the result holds until taken; the back waits with its
//   next op, the queue fills, and then s_ready drops.
`default_nettype none

module key_value_table #(
    parameter int CAPACITY   = 16,
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 32
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic [kvt_pkg::OP_BITS-1:0]        s_operation,
    input  wire logic [kvt_pkg::FIELD_BITS-1:0]     s_key,
    input  wire logic [kvt_pkg::FIELD_BITS-1:0]     s_value,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic                                    m_ok,
    output logic                                    m_full_reject,
    output logic [kvt_pkg::FIELD_BITS-1:0]          m_value_out,
    output logic [kvt_pkg::COUNT_OUT_W-1:0]         m_entry_count,
    output logic                                    m_is_empty
);
    import kvt_pkg::*;

    // stored widths: the ports carry 32 bits, so wider settings add nothing
    localparam int KEY_W   = (KEY_BITS < FIELD_BITS) ? KEY_BITS : FIELD_BITS;
    localparam int VALUE_W = (VALUE_BITS < FIELD_BITS) ? VALUE_BITS : FIELD_BITS;

    logic q_valid;
    logic q_pop;
    req_t q_head;

    kvt_front #(
        .KEY_W   (KEY_W),
        .VALUE_W (VALUE_W)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_operation (s_operation),
        .s_key       (s_key),
        .s_value     (s_value),
        .q_valid     (q_valid),
        .q_pop       (q_pop),
        .q_head      (q_head)
    );

    kvt_back #(
        .CAPACITY (CAPACITY),
        .KEY_W    (KEY_W),
        .VALUE_W  (VALUE_W)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_valid       (q_valid),
        .q_pop         (q_pop),
        .q_head        (q_head),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_ok          (m_ok),
        .m_full_reject (m_full_reject),
        .m_value_out   (m_value_out),
        .m_entry_count (m_entry_count),
        .m_is_empty    (m_is_empty)
    );

endmodule : key_value_table

`default_nettype wire

// ----- bench/key_value_table_test.sv -----
`timescale 1ns / 1ps

module key_value_table_test;
    import kvt_pkg::*;

    localparam int TABLE_SLOTS   = 16;
    localparam int STALL_LIMIT   = 2000;   // cycles without any handshake
    localparam int DRAIN_CYCLES  = 20;     // tail after the last result
    localparam int KEY_POOL_SIZE = 24;     // a few more keys than slots
    localparam int RANDOM_ITEMS  = 156;    // per random phase

    // One result item, in port order.
    typedef struct packed {
        logic                   ok;
        logic                   full_reject;
        logic [FIELD_BITS-1:0]  value_out;
        logic [COUNT_OUT_W-1:0] entry_count;
        logic                   is_empty;
    } table_result_t;

    // Tracks the table contents, queues the expected result of every
    // accepted item and checks results in order.
    class table_tracker;
        bit                    slot_used [TABLE_SLOTS];
        logic [FIELD_BITS-1:0] slot_key  [TABLE_SLOTS];
        logic [FIELD_BITS-1:0] slot_value[TABLE_SLOTS];
        int                    used_count;
        table_result_t         expected_results[$];
        int                    mismatches;
        int                    results_seen;

        function new();
            used_count   = 0;
            mismatches   = 0;
            results_seen = 0;
            foreach (slot_used[i]) slot_used[i] = 1'b0;
        endfunction

        // Applies one operation to the tracked table and returns its result.
        function table_result_t predict_op(op_t op, logic [FIELD_BITS-1:0] key,
                                           logic [FIELD_BITS-1:0] value);
            table_result_t r;
            int            hit;
            int            free_slot;
            r         = '0;
            hit       = -1;
            free_slot = -1;
            for (int i = 0; i < TABLE_SLOTS; i++) begin
                if (slot_used[i] && slot_key[i] == key && hit < 0)
                    hit = i;
                if (!slot_used[i] && free_slot < 0)
                    free_slot = i;
            end
            case (op)
                OP_ADD: begin
                    // duplicate key wins over a full table
                    if (hit < 0) begin
                        if (used_count >= TABLE_SLOTS) begin
                            r.full_reject = 1'b1;
                        end else begin
                            slot_used[free_slot]  = 1'b1;
                            slot_key[free_slot]   = key;
                            slot_value[free_slot] = value;
                            used_count++;
                            r.ok = 1'b1;
                        end
                    end
                end
                OP_FIND: begin
                    r.ok = (hit >= 0);
                end
                OP_RETRIEVE: begin
                    if (hit >= 0) begin
                        r.ok        = 1'b1;
                        r.value_out = slot_value[hit];
                    end
                end
                OP_REMOVE: begin
                    if (hit >= 0) begin
                        slot_used[hit] = 1'b0;
                        used_count--;
                        r.ok = 1'b1;
                    end
                end
            endcase
            r.entry_count = used_count[COUNT_OUT_W-1:0];
            r.is_empty    = (used_count == 0);
            return r;
        endfunction

        function void note_request(op_t op, logic [FIELD_BITS-1:0] key,
                                   logic [FIELD_BITS-1:0] value);
            expected_results.push_back(predict_op(op, key, value));
        endfunction

        function void check_result(table_result_t got);
            table_result_t want;
            results_seen++;
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result %0d arrived with nothing outstanding: %p",
                             results_seen, got);
                return;
            end
            want = expected_results.pop_front();
            if (got.ok !== want.ok || got.full_reject !== want.full_reject ||
                got.value_out !== want.value_out ||
                got.entry_count !== want.entry_count ||
                got.is_empty !== want.is_empty) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result %0d mismatch: expected %p, got %p",
                             results_seen, want, got);
            end
        endfunction

        function int pending();
            return expected_results.size();
        endfunction
    endclass

    logic                   aclk          = 1'b0;
    logic                   aresetn       = 1'b0;
    logic                   s_valid       = 1'b0;
    logic                   s_ready;
    logic [OP_BITS-1:0]     s_operation   = '0;
    logic [FIELD_BITS-1:0]  s_key         = '0;
    logic [FIELD_BITS-1:0]  s_value       = '0;
    logic                   m_valid;
    logic                   m_ready       = 1'b0;
    logic                   m_ok;
    logic                   m_full_reject;
    logic [FIELD_BITS-1:0]  m_value_out;
    logic [COUNT_OUT_W-1:0] m_entry_count;
    logic                   m_is_empty;

    // Percent chance per cycle of the sender idling / the receiver stalling.
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int quiet_cycles   = 0;

    logic [FIELD_BITS-1:0] key_pool[KEY_POOL_SIZE];

    table_tracker tracker = new();

    key_value_table u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_operation   (s_operation),
        .s_key         (s_key),
        .s_value       (s_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_ok          (m_ok),
        .m_full_reject (m_full_reject),
        .m_value_out   (m_value_out),
        .m_entry_count (m_entry_count),
        .m_is_empty    (m_is_empty)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Receiver: stall at random according to the current phase.
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Result side: every accepted result goes to the tracker, in order.
    always @(posedge aclk) begin : result_monitor
        table_result_t seen;
        if (aresetn && m_valid && m_ready) begin
            seen = {m_ok, m_full_reject, m_value_out, m_entry_count, m_is_empty};
            tracker.check_result(seen);
        end
    end

    // Watchdog: give up once no item has moved on either side for too long.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Presents one item, optionally idling first, and holds it until accepted.
    // Valid stays high into the next item when there is no idle gap.
    task automatic send_item(input op_t op, input logic [FIELD_BITS-1:0] key,
                             input logic [FIELD_BITS-1:0] value);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(0, 99) < send_idle_pct);
        end
        s_valid     <= 1'b1;
        s_operation <= op;
        s_key       <= key;
        s_value     <= value;
        do @(posedge aclk); while (!s_ready);
        tracker.note_request(op, key, value);
    endtask

    // Sender stops and waits until every expected result has come back.
    task automatic drain_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (tracker.pending() != 0);
    endtask

    task automatic refill_key_pool();
        foreach (key_pool[i]) key_pool[i] = $urandom;
        key_pool[0] = '0;
        key_pool[1] = '1;
    endtask

    // Random items biased to swing the table between full and empty:
    // filling stretches favor adds, draining stretches favor removes.
    task automatic random_items(input int count);
        op_t                   op;
        logic [FIELD_BITS-1:0] key;
        int                    pick;
        bit                    filling;
        for (int n = 0; n < count; n++) begin
            filling = ((n / 40) % 2 == 0);
            pick    = $urandom_range(0, 99);
            if (filling)
                op = (pick < 50) ? OP_ADD : (pick < 65) ? OP_FIND :
                     (pick < 85) ? OP_RETRIEVE : OP_REMOVE;
            else
                op = (pick < 15) ? OP_ADD : (pick < 30) ? OP_FIND :
                     (pick < 50) ? OP_RETRIEVE : OP_REMOVE;
            // mostly pool keys so lookups hit; the rest are fresh misses
            if ($urandom_range(0, 99) < 88)
                key = key_pool[$urandom_range(0, KEY_POOL_SIZE - 1)];
            else
                key = $urandom;
            send_item(op, key, $urandom);
        end
    endtask

    initial begin
        // Synchronous reset, held at the start, then released.
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: empty-table operations, extreme keys and values,
        // duplicate add, misses, fill to capacity, then add on a full table
        // (new key and duplicate key), retrieve and remove at full.
        send_item(OP_REMOVE,   32'h0000_0000, $urandom);
        send_item(OP_FIND,     32'h0000_0000, $urandom);
        send_item(OP_RETRIEVE, 32'h0000_0000, $urandom);
        send_item(OP_ADD,      32'h0000_0000, 32'h0000_0000);
        send_item(OP_ADD,      32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(OP_ADD,      32'hFFFF_FFFF, 32'h1234_5678);
        send_item(OP_RETRIEVE, 32'hFFFF_FFFF, $urandom);
        send_item(OP_RETRIEVE, 32'h0000_0000, $urandom);
        send_item(OP_FIND,     32'h0000_0005, $urandom);
        send_item(OP_RETRIEVE, 32'h0000_0005, $urandom);
        send_item(OP_REMOVE,   32'h0000_0005, $urandom);
        for (int i = 1; i <= TABLE_SLOTS - 2; i++)
            send_item(OP_ADD, 32'hA5A5_0000 | i, ~(32'h1 << i));
        send_item(OP_ADD,      32'h5555_5555, $urandom);
        send_item(OP_ADD,      32'h0000_0000, $urandom);
        send_item(OP_RETRIEVE, 32'hA5A5_0007, $urandom);
        send_item(OP_REMOVE,   32'h0000_0000, $urandom);
        send_item(OP_ADD,      32'h5555_5555, 32'hAAAA_AAAA);
        drain_results();

        // Random phases: no idling, slow sender, slow receiver, both slow.
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 78; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 78; end
                default: begin send_idle_pct = 6; recv_stall_pct = 6; end
            endcase
            refill_key_pool();
            random_items(RANDOM_ITEMS);
            drain_results();
        end

        recv_stall_pct = 0;
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (tracker.mismatches == 0 && tracker.pending() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ----- key_value_table.f -----
sv/kvt_pkg.sv
sv/kvt_front.sv
sv/kvt_back.sv
sv/key_value_table.sv
bench/key_value_table_test.sv
